@@ rtl/lapedge_pkg.sv @@
`timescale 1ns / 1ps

package lapedge_pkg;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int ROW_W   = 13;

    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [10:0] FRAME_WIDTH_RST    = 11'd1024;
    localparam logic [11:0] FRAME_HEIGHT_RST   = 12'd1;
    localparam logic [11:0] EDGE_THRESHOLD_RST = 12'd0;

    localparam logic [15:0] GRAY_R    = 16'd77;
    localparam logic [15:0] GRAY_G    = 16'd150;
    localparam logic [15:0] GRAY_B    = 16'd29;
    localparam logic [15:0] GRAY_RND  = 16'd128;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       flush;
    } pix_in_t;

    typedef struct packed {
        logic              edge_res;
        logic signed [11:0] laplacian_sum;
        logic              frame_end;
    } pix_out_t;

    typedef struct packed {
        logic final_item;
        logic row_end;
        logic pix_out;
        logic drain;
        logic use_newer;
        logic use_older;
    } pos_t;

    typedef struct packed {
        logic [7:0] older;
        logic [7:0] newer;
    } row_pair_t;

endpackage

@@ rtl/lapedge_ctrl.sv @@
`timescale 1ns / 1ps

module lapedge_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [10:0]                frame_width,
    input  logic [11:0]                frame_height,
    input  logic                       accept,
    input  lapedge_pkg::pix_in_t       in_data,
    output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output lapedge_pkg::pos_t          s1_pos,
    output logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
    output logic [7:0]                 s1_gray
);
    import lapedge_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;

    logic [AW-1:0]    col_reg;
    logic [AW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    pos_t             s1_pos_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic [7:0]       s1_gray_reg;

    logic [CW-1:0]    w_eff;
    logic [11:0]      h_eff;
    logic             wrap;
    logic [AW-1:0]    col;
    logic [ROW_W-1:0] row;
    logic [CW-1:0]    col_inc;
    logic [15:0]      gray_acc;
    logic [7:0]       gray;
    pos_t             pos;

    always_comb
    begin
        if (frame_width == 11'd0)
            w_eff = CW'(1);
        else if (CW'(frame_width) > CW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(frame_width);
        h_eff = (frame_height == 12'd0) ? 12'd1 : frame_height;

        wrap = CW'(col_reg) >= w_eff;
        col  = wrap ? '0 : col_reg;
        row  = wrap ? row_reg + ROW_W'(1) : row_reg;

        pos.final_item = row >= ROW_W'(h_eff) + ROW_W'(1);
        pos.drain      = row >= ROW_W'(h_eff);
        pos.row_end    = !pos.final_item && (col == '0) && (row >= ROW_W'(2));
        pos.pix_out    = !pos.final_item && (col != '0) && (row >= ROW_W'(1));
        pos.use_newer  = row >= ROW_W'(1);
        pos.use_older  = row >= ROW_W'(2);

        col_inc = CW'(col) + CW'(1);
        if (pos.final_item)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = row + ROW_W'(1);
        end
        else
        begin
            col_next = col_inc[AW-1:0];
            row_next = row;
        end

        gray_acc = GRAY_R * 16'(in_data.red) + GRAY_G * 16'(in_data.green)
                 + GRAY_B * 16'(in_data.blue) + GRAY_RND;
        gray     = pos.drain ? 8'd0 : gray_acc[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg  <= pos;
            s1_addr_reg <= col;
            s1_gray_reg <= gray;
        end
    end

    assign rd_addr = col;
    assign s1_pos  = s1_pos_reg;
    assign s1_addr = s1_addr_reg;
    assign s1_gray = s1_gray_reg;

endmodule

@@ rtl/lapedge_line_mem.sv @@
`timescale 1ns / 1ps

module lapedge_line_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  lapedge_pkg::row_pair_t    wr_data,
    output lapedge_pkg::row_pair_t    rd_data
);
    import lapedge_pkg::*;

    row_pair_t mem [DEPTH];
    row_pair_t rd_q_reg;
    row_pair_t fwd_data_reg;
    logic      fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // forward a write that lands on the same edge as the read of its entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (rd_en)
            fwd_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_q_reg;

endmodule

@@ rtl/lapedge_window.sv @@
`timescale 1ns / 1ps

module lapedge_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  lapedge_pkg::pos_t         pos,
    input  logic [7:0]                top_pix,
    input  logic [7:0]                mid_pix,
    input  logic [7:0]                bot_pix,
    input  logic signed [11:0]        threshold,
    output lapedge_pkg::pix_out_t     result
);
    import lapedge_pkg::*;

    logic [7:0]         win_reg [3][3];
    logic               first_col_reg;
    logic [7:0]         col_in [3];
    logic [7:0]         lft [3];
    logic [7:0]         rgt [3];
    logic [10:0]        ring;
    logic signed [11:0] sum;

    always_comb
    begin
        col_in[0] = top_pix;
        col_in[1] = mid_pix;
        col_in[2] = bot_pix;
        for (int k = 0; k < 3; k++)
        begin
            lft[k] = first_col_reg ? win_reg[k][2] : win_reg[k][1];
            rgt[k] = pos.pix_out ? col_in[k] : win_reg[k][2];
        end
        ring = 11'(lft[0]) + 11'(win_reg[0][2]) + 11'(rgt[0])
             + 11'(lft[1]) + 11'(rgt[1])
             + 11'(lft[2]) + 11'(win_reg[2][2]) + 11'(rgt[2]);
        sum  = signed'({1'b0, win_reg[1][2], 3'b000}) - signed'({1'b0, ring});

        result.edge_res      = sum > threshold;
        result.laplacian_sum = sum;
        result.frame_end     = pos.final_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_col_reg <= 1'b1;
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    win_reg[k][j] <= 8'd0;
        end
        else if (go)
        begin
            if (pos.final_item || pos.row_end)
                first_col_reg <= 1'b1;
            else if (pos.pix_out)
                first_col_reg <= 1'b0;
            if (!pos.final_item)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k][0] <= win_reg[k][1];
                    win_reg[k][1] <= win_reg[k][2];
                    win_reg[k][2] <= col_in[k];
                end
            end
        end
    end

endmodule

@@ rtl/laplacian_edge_threshold_core.sv @@
`timescale 1ns / 1ps

// Streaming 3x3 Laplacian edge detector for raster-order RGB pixels. Each pixel is
// turned to 8-bit gray, the response 8*centre minus the eight neighbours is formed
// with border pixels replicated, and edge_res is 1 when that response exceeds the
// signed edge_threshold. Set frame_width, frame_height and edge_threshold while the
// block is idle, send width*height pixels, then width+1 flush transactions to drain
// the last row; the final result carries frame_end. One transaction is taken per
// clock while in_stall is low; the result of a pixel appears width+1 transactions
// after it, held first in the stage-1 registers, then in the output register. The
// two previous gray rows sit in one MAX_WIDTH-deep memory read at the column address
// each transaction, rewritten outside the drain rows; same-edge writes are forwarded.
module laplacian_edge_threshold_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lapedge_pkg::PADDR_W-1:0]      paddr,
    input  logic [lapedge_pkg::PDATA_W-1:0]      pwdata,
    output logic [lapedge_pkg::PDATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  lapedge_pkg::pix_in_t                 in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output lapedge_pkg::pix_out_t                out_data
);
    import lapedge_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [10:0]        frame_width_reg;
    logic [11:0]        frame_height_reg;
    logic signed [11:0] edge_threshold_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    pix_out_t           out_data_reg;

    logic               cfg_wr;
    logic               accept;
    logic               s1_has_res;
    logic               out_free;
    logic               s1_go;
    logic [AW-1:0]      rd_addr;
    pos_t               s1_pos;
    logic [AW-1:0]      s1_addr;
    logic [7:0]         s1_gray;
    row_pair_t          mem_rd;
    row_pair_t          mem_wr;
    logic               mem_wr_en;
    logic [7:0]         mid_pix;
    logic [7:0]         top_pix;
    logic [7:0]         bot_pix;
    pix_out_t           result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FRAME_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            edge_threshold_reg <= EDGE_THRESHOLD_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:    frame_width_reg    <= pwdata[10:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= pwdata[11:0];
                REG_EDGE_THRESHOLD: edge_threshold_reg <= pwdata[11:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:    prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT:   prdata = PDATA_W'(frame_height_reg);
            REG_EDGE_THRESHOLD: prdata = PDATA_W'(unsigned'(edge_threshold_reg));
            default:            prdata = '0;
        endcase
    end

    assign s1_has_res = s1_pos.final_item || s1_pos.row_end || s1_pos.pix_out;
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_go      = s1_valid_reg && (!s1_has_res || out_free);
    assign in_stall   = s1_valid_reg && !s1_go;
    assign accept     = in_valid && !in_stall;

    lapedge_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .accept       (accept),
        .in_data      (in_data),
        .rd_addr      (rd_addr),
        .s1_pos       (s1_pos),
        .s1_addr      (s1_addr),
        .s1_gray      (s1_gray)
    );

    assign mid_pix      = s1_pos.use_newer ? mem_rd.newer : s1_gray;
    assign top_pix      = s1_pos.use_older ? mem_rd.older : mid_pix;
    assign bot_pix      = s1_pos.drain ? mid_pix : s1_gray;
    assign mem_wr.older = mem_rd.newer;
    assign mem_wr.newer = s1_gray;
    assign mem_wr_en    = s1_go && !s1_pos.drain;

    lapedge_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (mem_wr_en),
        .wr_addr (s1_addr),
        .wr_data (mem_wr),
        .rd_data (mem_rd)
    );

    lapedge_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (s1_go),
        .pos       (s1_pos),
        .top_pix   (top_pix),
        .mid_pix   (mid_pix),
        .bot_pix   (bot_pix),
        .threshold (edge_threshold_reg),
        .result    (result)
    );

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_go && s1_has_res)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_has_res)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

import lapedge_pkg::*;

class edge_scoreboard;
    localparam int ROW_DEPTH = 1024;

    logic [10:0]        cfg_width;
    logic [11:0]        cfg_height;
    logic signed [11:0] cfg_thresh;
    logic [7:0]         older_row[ROW_DEPTH];
    logic [7:0]         newer_row[ROW_DEPTH];
    logic [7:0]         gray_win[9];
    int                 in_col;
    int                 in_row;
    int                 out_col;
    pix_out_t           expected_q[$];
    int                 errors;
    int                 accepted;
    int                 compared;

    function new();
        cfg_width  = FRAME_WIDTH_RST;
        cfg_height = FRAME_HEIGHT_RST;
        cfg_thresh = EDGE_THRESHOLD_RST;
        foreach (older_row[i]) older_row[i] = 8'd0;
        foreach (newer_row[i]) newer_row[i] = 8'd0;
        foreach (gray_win[i]) gray_win[i] = 8'd0;
        in_col   = 0;
        in_row   = 0;
        out_col  = 0;
        errors   = 0;
        accepted = 0;
        compared = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            REG_FRAME_WIDTH:    cfg_width  = value[10:0];
            REG_FRAME_HEIGHT:   cfg_height = value[11:0];
            REG_EDGE_THRESHOLD: cfg_thresh = value[11:0];
            default: ;
        endcase
    endfunction

    function pix_out_t window_response(int l, int m, int r, bit last_px);
        pix_out_t res;
        int ring;
        int sum;
        ring = int'(gray_win[l]) + int'(gray_win[m]) + int'(gray_win[r])
             + int'(gray_win[3 + l]) + int'(gray_win[3 + r])
             + int'(gray_win[6 + l]) + int'(gray_win[6 + m]) + int'(gray_win[6 + r]);
        sum = 8 * int'(gray_win[3 + m]) - ring;
        res.edge_res      = (sum > int'(cfg_thresh));
        res.laplacian_sum = 12'(sum);
        res.frame_end     = last_px;
        return res;
    endfunction

    function void note_pixel(pix_in_t d);
        int         w;
        int         h;
        int         ic;
        int         ir;
        int         acc;
        bit         drain;
        logic [7:0] gray;
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
        accepted++;
        w = cfg_width;
        if (w == 0) w = 1;
        if (w > ROW_DEPTH) w = ROW_DEPTH;
        h = cfg_height;
        if (h == 0) h = 1;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        ic = in_col;
        ir = in_row;
        if (ir >= h + 1)
        begin
            expected_q.push_back(window_response((out_col == 0) ? 2 : 1, 2, 2, 1'b1));
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            return;
        end
        if (ic == 0 && ir >= 2)
        begin
            expected_q.push_back(window_response((out_col == 0) ? 2 : 1, 2, 2, 1'b0));
            out_col = 0;
        end
        drain = (ir >= h);
        gray  = 8'd0;
        if (!drain)
        begin
            acc = int'(GRAY_R) * int'(d.red) + int'(GRAY_G) * int'(d.green)
                + int'(GRAY_B) * int'(d.blue) + int'(GRAY_RND);
            gray = 8'(acc >> 8);
        end
        mid = (ir >= 1) ? newer_row[ic] : gray;
        top = (ir >= 2) ? older_row[ic] : mid;
        bot = drain ? mid : gray;
        if (!drain)
        begin
            older_row[ic] = newer_row[ic];
            newer_row[ic] = gray;
        end
        for (int k = 0; k < 3; k++)
        begin
            gray_win[k * 3 + 0] = gray_win[k * 3 + 1];
            gray_win[k * 3 + 1] = gray_win[k * 3 + 2];
        end
        gray_win[2] = top;
        gray_win[5] = mid;
        gray_win[8] = bot;
        if (ic >= 1 && ir >= 1)
        begin
            expected_q.push_back(window_response((out_col == 0) ? 1 : 0, 1, 2, 1'b0));
            out_col = (out_col + 1) & 'h3FF;
        end
        ic++;
        if (ic >= w)
        begin
            ic = 0;
            ir++;
        end
        in_col = ic;
        in_row = ir;
    endfunction

    function void check_result(pix_out_t got);
        pix_out_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result: sum %0d edge %0b end %0b", $time,
                     got.laplacian_sum, got.edge_res, got.frame_end);
            return;
        end
        want = expected_q.pop_front();
        compared++;
        if (got.edge_res !== want.edge_res)
        begin
            errors++;
            $display("%0t: edge_res expected %0b actual %0b", $time,
                     want.edge_res, got.edge_res);
        end
        if (got.laplacian_sum !== want.laplacian_sum)
        begin
            errors++;
            $display("%0t: laplacian_sum expected %0d actual %0d", $time,
                     want.laplacian_sum, got.laplacian_sum);
        end
        if (got.frame_end !== want.frame_end)
        begin
            errors++;
            $display("%0t: frame_end expected %0b actual %0b", $time,
                     want.frame_end, got.frame_end);
        end
    endfunction

    function int outstanding();
        return expected_q.size();
    endfunction
endclass

module testbench;
    localparam int MAX_W = 1024;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    pix_in_t              in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    pix_out_t             out_data;

    edge_scoreboard       sb = new();
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   holdoff_left = 0;
    int                   frames = 0;

    laplacian_edge_threshold_core #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) sb.note_pixel(in_data);
            if (out_valid && !out_stall) sb.check_result(out_data);
        end
    end

    // hold off for a counted stretch when asked, else stall at random
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            out_stall <= 1'b1;
            holdoff_left = holdoff_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        #3ms;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic program_frame(input int w, input int h, input int thr);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        reg_write(REG_FRAME_WIDTH, 32'(w) & 32'h7FF);
        reg_write(REG_FRAME_HEIGHT, 32'(h) & 32'hFFF);
        reg_write(REG_EDGE_THRESHOLD, 32'(thr) & 32'hFFF);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(input pix_in_t d);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic f);
        pix_in_t d;
        d.red   = r;
        d.green = g;
        d.blue  = b;
        d.flush = f;
        send_item(d);
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_frame(input int w, input int h, input int noise_pct);
        int wq;
        int hq;
        wq = (w == 0) ? 1 : (w > MAX_W) ? MAX_W : w;
        hq = (h == 0) ? 1 : h;
        for (int i = 0; i < wq * hq; i++)
            send_rgb(pick_channel(), pick_channel(), pick_channel(),
                     $urandom_range(0, 99) < noise_pct);
        for (int i = 0; i <= wq; i++)
            send_rgb(pick_channel(), pick_channel(), pick_channel(),
                     !($urandom_range(0, 99) < noise_pct));
        frames++;
    endtask

    function automatic int pick_thresh();
        if ($urandom_range(0, 3) != 0) return $urandom_range(0, 600) - 300;
        return $urandom_range(0, 4095) - 2048;
    endfunction

    initial
    begin
        int w;
        int h;
        int phase_items;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bright center on black, with primaries along the bottom row
        program_frame(3, 3, 0);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b0);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b1);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b0);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b0);
        send_rgb(8'd255, 8'd255, 8'd255, 1'b0);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b0);
        send_rgb(8'd255, 8'd0, 8'd0, 1'b0);
        send_rgb(8'd0, 8'd255, 8'd0, 1'b0);
        send_rgb(8'd0, 8'd0, 8'd255, 1'b0);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b1);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b1);
        send_rgb(8'd255, 8'd255, 8'd255, 1'b0);
        send_rgb(8'd0, 8'd0, 8'd0, 1'b1);
        frames++;
        // dark center on white
        program_frame(3, 3, -2048);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4) send_rgb(8'd0, 8'd0, 8'd0, 1'b0);
            else send_rgb(8'd255, 8'd255, 8'd255, 1'b0);
        end
        for (int i = 0; i < 4; i++) send_rgb(8'd0, 8'd0, 8'd0, 1'b1);
        frames++;
        // zero geometry acts as a single pixel
        program_frame(0, 0, 2047);
        run_frame(0, 0, 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 51;
                end
                default:
                begin
                    send_idle_pct = 12;
                    recv_stall_pct = 12;
                end
            endcase
            phase_items = 0;
            if (phase == 0)
            begin
                program_frame(32, 3, pick_thresh());
                holdoff_left = 400;
                run_frame(32, 3, 0);
            end
            while (phase_items < 110)
            begin
                case ($urandom_range(0, 3))
                    0:       w = 1;
                    1:       w = $urandom_range(2, 4);
                    default: w = $urandom_range(2, 16);
                endcase
                h = $urandom_range(1, 6);
                program_frame(w, h, pick_thresh());
                run_frame(w, h, 10);
                phase_items += w * h + w + 1;
            end
        end

        // tall single-column frame
        program_frame(1, 30, pick_thresh());
        run_frame(1, 30, 5);

        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("run: %0d frames over four pacing phases, %0d transactions accepted",
                 frames, sb.accepted);
        $display("run: %0d results compared, widths 0..32, heights 0..30, full threshold",
                 sb.compared);
        if (sb.errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
